// ===== design/ced_pkg.sv =====
// Shared types, codes and lookup functions for the C escape decoder.
package ced_pkg;

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_ESC     = 3'd1;
    localparam logic [2:0] MODE_HEX1    = 3'd2;
    localparam logic [2:0] MODE_HEX2    = 3'd3;
    localparam logic [2:0] MODE_DISCARD = 3'd4;

    localparam logic [2:0] ST_DATA    = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_HEXERR  = 3'd4;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X         = 8'h78;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } res_t;

    // Returns {hit, control byte} for the ten simple escape letters.
    function automatic logic [8:0] esc_lookup(input logic [7:0] c);
        logic [8:0] r;
        begin
            case (c)
                8'h27:   r = {1'b1, 8'h27};
                8'h22:   r = {1'b1, 8'h22};
                8'h5C:   r = {1'b1, 8'h5C};
                8'h61:   r = {1'b1, 8'h07};
                8'h62:   r = {1'b1, 8'h08};
                8'h66:   r = {1'b1, 8'h0C};
                8'h6E:   r = {1'b1, 8'h0A};
                8'h72:   r = {1'b1, 8'h0D};
                8'h74:   r = {1'b1, 8'h09};
                8'h76:   r = {1'b1, 8'h0B};
                default: r = {1'b0, 8'h00};
            endcase
            return r;
        end
    endfunction

    // Returns {bad, nibble}; bad is set for anything that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b0, 4'(c - 8'h30)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                r = {1'b0, 4'(c - 8'h57)};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                r = {1'b0, 4'(c - 8'h37)};
            end else begin
                r = 5'h10;
            end
            return r;
        end
    endfunction

endpackage

// ===== design/ced_stream_if.sv =====
// Valid/ready channel interfaces for the input and result streams.
interface ced_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       terminator;

    modport source (output valid, output in_byte, output terminator, input ready);
    modport sink   (input valid, input in_byte, input terminator, output ready);
endinterface

interface ced_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== design/ced_decode.sv =====
// Escape parser state and the per-byte decode logic.
module ced_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic [7:0]    in_byte,
    input  logic          terminator,
    output ced_pkg::res_t res
);
    import ced_pkg::*;

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic [3:0] nib_reg;
    logic [3:0] nib_next;
    logic [8:0] esc;
    logic [4:0] hex;

    assign esc = esc_lookup(in_byte);
    assign hex = hex_value(in_byte);

    always_comb
    begin
        mode_next    = mode_reg;
        nib_next     = nib_reg;
        res.valid    = 1'b0;
        res.out_byte = 8'h00;
        res.status   = ST_DATA;
        res.last     = 1'b0;
        case (mode_reg)
            MODE_ESC:
            begin
                res.valid = 1'b1;
                if (terminator) begin
                    mode_next  = MODE_NORMAL;
                    res.status = ST_MISSING;
                    res.last   = 1'b1;
                end else if (esc[8]) begin
                    mode_next    = MODE_NORMAL;
                    res.out_byte = esc[7:0];
                end else if (in_byte == CHAR_X) begin
                    mode_next = MODE_HEX1;
                    res.valid = 1'b0;
                end else begin
                    mode_next  = MODE_DISCARD;
                    res.status = ST_UNKNOWN;
                    res.last   = 1'b1;
                end
            end
            MODE_HEX1, MODE_HEX2:
            begin
                res.valid = 1'b1;
                if (terminator) begin
                    mode_next  = MODE_NORMAL;
                    res.status = ST_HEXERR;
                    res.last   = 1'b1;
                end else if (hex[4]) begin
                    mode_next  = MODE_DISCARD;
                    res.status = ST_HEXERR;
                    res.last   = 1'b1;
                end else if (mode_reg == MODE_HEX1) begin
                    nib_next  = hex[3:0];
                    mode_next = MODE_HEX2;
                    res.valid = 1'b0;
                end else begin
                    mode_next    = MODE_NORMAL;
                    res.out_byte = {nib_reg, hex[3:0]};
                end
            end
            MODE_DISCARD:
            begin
                if (terminator) begin
                    mode_next = MODE_NORMAL;
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
                res.valid = 1'b1;
                if (terminator) begin
                    res.status = ST_DONE;
                    res.last   = 1'b1;
                end else if (in_byte == CHAR_BACKSLASH) begin
                    mode_next = MODE_ESC;
                    res.valid = 1'b0;
                end else begin
                    res.out_byte = in_byte;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_NORMAL;
            nib_reg  <= 4'h0;
        end else if (advance) begin
            mode_reg <= mode_next;
            nib_reg  <= nib_next;
        end
    end

endmodule

// ===== design/c_escape_decoder.sv =====
// Flow: an input beat is taken into the input register, decoded, and its result is
// registered in the result register that drives dout, unless a stalled dout holds it.
// Throughput: one input beat per cycle; the input register, one decode pass
// and the result register set that figure, and a stalled dout holds the line.
// Reset: rst_n clears both stage valids, parse mode to normal, hex nibble to 0.
// Top level of the C escape decoder.
module c_escape_decoder (
    input  logic      clk,
    input  logic      rst_n,
    ced_in_if.sink    din,
    ced_out_if.source dout
);
    import ced_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_term_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [2:0] out_status_reg;
    logic       out_last_reg;
    logic       out_free;
    logic       advance;
    res_t       res;

    ced_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_byte    (in_byte_reg),
        .terminator (in_term_reg),
        .res        (res)
    );

    // A byte that yields no result moves on even while the output is stalled.
    assign out_free  = !out_valid_reg || dout.ready;
    assign advance   = in_valid_reg && (!res.valid || out_free);
    assign din.ready = !in_valid_reg || advance;

    assign dout.valid    = out_valid_reg;
    assign dout.out_byte = out_byte_reg;
    assign dout.status   = out_status_reg;
    assign dout.last     = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (din.ready) begin
            in_valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready) begin
            in_byte_reg <= din.in_byte;
            in_term_reg <= din.terminator;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (dout.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid) begin
            out_byte_reg   <= res.out_byte;
            out_status_reg <= res.status;
            out_last_reg   <= res.last;
        end
    end

`ifndef SYNTHESIS
    a_data_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.status == ST_DATA) |-> !dout.last)
        else $error("data beat marked as last");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.status != ST_DATA) |-> (dout.last && dout.out_byte == 8'h00))
        else $error("done or error beat without last or with a nonzero byte");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> (dout.status <= ST_HEXERR))
        else $error("result status out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.valid) |-> out_free)
        else $error("result register overwritten while still pending");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the C escape decoder: directed and random strings.
module tb_top;
    import ced_pkg::*;

    localparam int TIMEOUT_CYCLES = 300000;
    localparam int RANDOM_BEATS   = 310;
    localparam int TAIL_CYCLES    = 8;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] code;
        logic       ends;
    } decoded_t;

    logic clk = 1'b0;
    logic rst_n;

    ced_in_if  in_ch ();
    ced_out_if out_ch ();

    c_escape_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (in_ch),
        .dout  (out_ch)
    );

    // Decoder state as the testbench sees it.
    logic [2:0] decode_mode;
    logic [3:0] hex_hi;
    decoded_t   decoded_q[$];
    decoded_t   head_result;

    int  error_count = 0;
    int  cycle_count = 0;
    int  beats_sent  = 0;
    int  sink_hold   = 0;
    bit  full_speed  = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, decoded_q.size());
            $display("status: fail");
            $finish;
        end
        else
        begin
            cycle_count++;
        end
    end

    function automatic int draw_gap();
        if (full_speed)
            return 0;
        return $urandom_range(0, 1) ? 0 : $urandom_range(1, 18);
    endfunction

    function automatic bit is_simple_escape(input logic [7:0] c);
        return c inside {8'h27, 8'h22, 8'h5C, "a", "b", "f", "n", "r", "t", "v"};
    endfunction

    function automatic logic [7:0] escape_value(input logic [7:0] c);
        case (c)
            "a":     return 8'h07;
            "b":     return 8'h08;
            "f":     return 8'h0C;
            "n":     return 8'h0A;
            "r":     return 8'h0D;
            "t":     return 8'h09;
            "v":     return 8'h0B;
            default: return c;
        endcase
    endfunction

    function automatic bit is_hex_digit(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] digit_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c <= "9")
            v = c - "0";
        else if (c >= "a")
            v = c - "a" + 8'd10;
        else
            v = c - "A" + 8'd10;
        return v[3:0];
    endfunction

    function automatic logic [7:0] random_hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10)
            return "0" + 8'(v);
        return ($urandom_range(0, 1) ? "a" : "A") + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_hex_digit(c));
        return c;
    endfunction

    task automatic push_result(input logic [7:0] data, input logic [2:0] code, input logic ends);
        decoded_t r;
        r.data = data;
        r.code = code;
        r.ends = ends;
        decoded_q.push_back(r);
    endtask

    // Advances the decoder state by one accepted beat and queues its result.
    task automatic predict_beat(input logic [7:0] c, input logic term);
        case (decode_mode)
            MODE_ESC:
            begin
                if (term)
                begin
                    decode_mode = MODE_NORMAL;
                    push_result(8'h00, ST_MISSING, 1'b1);
                end
                else if (is_simple_escape(c))
                begin
                    decode_mode = MODE_NORMAL;
                    push_result(escape_value(c), ST_DATA, 1'b0);
                end
                else if (c == CHAR_X)
                begin
                    decode_mode = MODE_HEX1;
                end
                else
                begin
                    decode_mode = MODE_DISCARD;
                    push_result(8'h00, ST_UNKNOWN, 1'b1);
                end
            end
            MODE_HEX1, MODE_HEX2:
            begin
                if (term)
                begin
                    decode_mode = MODE_NORMAL;
                    push_result(8'h00, ST_HEXERR, 1'b1);
                end
                else if (!is_hex_digit(c))
                begin
                    decode_mode = MODE_DISCARD;
                    push_result(8'h00, ST_HEXERR, 1'b1);
                end
                else if (decode_mode == MODE_HEX1)
                begin
                    hex_hi = digit_nibble(c);
                    decode_mode = MODE_HEX2;
                end
                else
                begin
                    decode_mode = MODE_NORMAL;
                    push_result({hex_hi, digit_nibble(c)}, ST_DATA, 1'b0);
                end
            end
            MODE_DISCARD:
            begin
                if (term)
                    decode_mode = MODE_NORMAL;
            end
            default:
            begin
                decode_mode = MODE_NORMAL;
                if (term)
                    push_result(8'h00, ST_DONE, 1'b1);
                else if (c == CHAR_BACKSLASH)
                    decode_mode = MODE_ESC;
                else
                    push_result(c, ST_DATA, 1'b0);
            end
        endcase
    endtask

    // Called right after a rising edge; returns in the step of the accepting edge.
    task automatic send_char(input logic [7:0] c, input logic term);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= c;
        in_ch.terminator <= term;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_beat(c, term);
        beats_sent++;
    endtask

    task automatic send_term();
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    // Holds the sender off until every queued result has been checked.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (decoded_q.size() != 0);
    endtask

    task automatic test_plain_and_simple();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("\\'\\\"\\\\\\a\\b\\f\\n\\r\\t\\v");
        send_term();
        send_term();
        drain_results();
    endtask

    task automatic test_hex_escapes();
        send_text("\\xFf\\x0a\\x9B");
        send_term();
        drain_results();
    endtask

    task automatic test_error_forms();
        send_text("\\");
        send_term();
        send_char(CHAR_BACKSLASH, 1'b0);
        send_char(8'h00, 1'b0);
        send_text("z\\");
        send_term();
        send_text("\\x");
        send_term();
        send_text("\\x4");
        send_term();
        send_text("\\x");
        send_char(8'h00, 1'b0);
        send_text("\\");
        send_term();
        send_text("\\x7g1");
        send_term();
        drain_results();
    endtask

    task automatic send_junk(input int count);
        for (int i = 0; i < count; i++)
            send_char(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Well-formed strings with random content, some of them broken near the end.
    task automatic send_random_string();
        logic [7:0] c;
        int         count;
        count = $urandom_range(0, 8);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 5))
                3, 4:
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (!is_simple_escape(c));
                    send_char(CHAR_BACKSLASH, 1'b0);
                    send_char(c, 1'b0);
                end
                5:
                begin
                    send_char(CHAR_BACKSLASH, 1'b0);
                    send_char(CHAR_X, 1'b0);
                    send_char(random_hex_char(), 1'b0);
                    send_char(random_hex_char(), 1'b0);
                end
                default:
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CHAR_BACKSLASH);
                    send_char(c, 1'b0);
                end
            endcase
        end
        if ($urandom_range(0, 3) == 0)
        begin
            send_char(CHAR_BACKSLASH, 1'b0);
            case ($urandom_range(0, 4))
                0: ;
                1:
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (is_simple_escape(c) || c == CHAR_X);
                    send_char(c, 1'b0);
                    send_junk($urandom_range(0, 4));
                end
                2: send_char(CHAR_X, 1'b0);
                3:
                begin
                    send_char(CHAR_X, 1'b0);
                    send_char(random_hex_char(), 1'b0);
                end
                default:
                begin
                    send_char(CHAR_X, 1'b0);
                    if ($urandom_range(0, 1))
                        send_char(random_hex_char(), 1'b0);
                    send_char(random_non_hex(), 1'b0);
                    send_junk($urandom_range(0, 4));
                end
            endcase
        end
        send_term();
    endtask

    // Unstructured beats, weighted toward the characters that steer the parser.
    task automatic send_noise();
        logic [7:0] c;
        int         count;
        count = $urandom_range(1, 10);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 4))
                0:       c = CHAR_BACKSLASH;
                1:       c = CHAR_X;
                2:       c = random_hex_char();
                default: c = 8'($urandom_range(0, 255));
            endcase
            send_char(c, $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic test_random_traffic(input int beat_budget);
        int stop_at;
        stop_at = beats_sent + beat_budget;
        while (beats_sent < stop_at)
        begin
            if ($urandom_range(0, 6) == 0)
                full_speed = ~full_speed;
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_random_string();
        end
        full_speed = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: out_byte=%02h status=%0d last=%0b",
                                 out_ch.out_byte, out_ch.status, out_ch.last);
                end
                else
                begin
                    head_result = decoded_q.pop_front();
                    if (out_ch.out_byte !== head_result.data || out_ch.status !== head_result.code
                        || out_ch.last !== head_result.ends)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                                     head_result.data, head_result.code, head_result.ends,
                                     out_ch.out_byte, out_ch.status, out_ch.last);
                    end
                end
                sink_hold = draw_gap();
            end
            if (sink_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                sink_hold--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = 8'h00;
        in_ch.terminator = 1'b0;
        out_ch.ready     = 1'b0;
        decode_mode      = MODE_NORMAL;
        hex_hi           = 4'h0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_plain_and_simple();
        test_hex_escapes();
        // Back-to-back beats on both sides through every error path.
        full_speed = 1'b1;
        test_error_forms();
        full_speed = 1'b0;
        test_error_forms();
        test_random_traffic(RANDOM_BEATS / 2);
        drain_results();
        test_random_traffic(RANDOM_BEATS / 2);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && decoded_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ced_pkg.sv
design/ced_stream_if.sv
design/ced_decode.sv
design/c_escape_decoder.sv
test/tb_top.sv
